// ===== hdl/binary_to_decimal_ascii_assert.svh =====
// Assertion macros for the binary to decimal ASCII converter.
// Included by modules that check their own control logic; needs no package.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Condition holds in the same cycle as the antecedent.
`define B2DA_ASSERT_NOW(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Condition holds in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== hdl/b2da_pkg.sv =====
// Shared types and constants of the binary to decimal ASCII converter.
// Used by the digit cell, the sequencer and the top level; depends on nothing.
package b2da_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned CHAR_W    = 6;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned BIT_CNT_W = 5;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE = 6'h39;
	localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd31;

	// Operation applied to all cells of the digit chain together.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_EMIT
	} state_t;

	// Control from the sequencer to the chain and the output register.
	typedef struct packed {
		cell_op_t op;
		logic     ser_bit;
		logic     emit;
		logic     is_last;
	} ctrl_t;

endpackage

// ===== hdl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter: a 32-bit unsigned number in, its decimal
// digits out as ASCII characters, most significant first, without leading zeros.
//
// Input channel (s_*): one word carries one number in s_tdata. The block takes a
// word only when idle, that is when the previous number has been fully handed to
// the output register.
// Output channel (m_*): one word per character; m_tlast marks the least
// significant digit. A value of zero gives the single character '0'. With
// MAX_DIGITS below ten only the lowest MAX_DIGITS decimal digits are kept.
//
// Steps: accept the number, then shift-add-3 through the chain of digit cells
// (one binary bit per cycle) for each of the 32 bits, then shift out leading
// zeros until the leading digit is found, then hand over one character at a time
// as the output register frees.
// Reset clears the sequencer and the output valid flag; the cells clear too.
// When the receiver stalls, the current character waits in the output register
// and the chain holds; nothing is lost. The next number can be accepted while
// the final character is still waiting.
module binary_to_decimal_ascii #(
	parameter int unsigned MAX_DIGITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] digit_char, [7:6] zero
	output logic        m_tlast    // last
);

	`include "binary_to_decimal_ascii_assert.svh"

	b2da_pkg::ctrl_t ctrl;

	// Chain wiring: bits travel up during conversion, whole digits travel up
	// during trimming and emission. Cell 0 is the least significant digit.
	logic [MAX_DIGITS:0]                 chain_bit;
	logic [b2da_pkg::DIGIT_W-1:0]        chain_digit [MAX_DIGITS+1];
	logic [b2da_pkg::DIGIT_W-1:0]        top_digit;
	logic                                out_free;

	logic                                out_valid_q;
	logic [b2da_pkg::CHAR_W-1:0]         out_char_q;
	logic                                out_last_q;

	assign chain_bit[0]   = ctrl.ser_bit;
	assign chain_digit[0] = '0;
	assign top_digit      = chain_digit[MAX_DIGITS];
	assign out_free       = !out_valid_q || m_tready;

	b2da_ctrl #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata),
		.top_zero (top_digit == '0),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		b2da_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (ctrl.op),
			.bit_in   (chain_bit[i]),
			.digit_in (chain_digit[i]),
			.bit_out  (chain_bit[i+1]),
			.digit    (chain_digit[i+1])
		);
	end

	// Output register: takes the top digit of the chain as it is shifted out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_char_q <= b2da_pkg::ASCII_ZERO
				+ {{(b2da_pkg::CHAR_W-b2da_pkg::DIGIT_W){1'b0}}, top_digit};
			out_last_q <= ctrl.is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_char_q};
	assign m_tlast  = out_last_q;

	// A shown character is always a decimal digit.
	`B2DA_ASSERT_NOW(a_char_range, clk, arst_n, m_tvalid,
		(m_tdata[5:0] >= b2da_pkg::ASCII_ZERO) && (m_tdata[5:0] <= b2da_pkg::ASCII_NINE))
	// Once a number is taken, the block is busy converting it.
	`B2DA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// Handing over the final digit frees the block for the next number.
	`B2DA_ASSERT_NEXT(a_idle_after_last, clk, arst_n, ctrl.emit && ctrl.is_last,
		s_tready && m_tvalid && m_tlast)

endmodule

// ===== hdl/b2da_cell.sv =====
// One BCD digit cell of the conversion chain: clear, shift-add-3 step or digit move.
// Depends on b2da_pkg.
module b2da_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  b2da_pkg::cell_op_t             op,
	input  logic                           bit_in,
	input  logic [b2da_pkg::DIGIT_W-1:0]   digit_in,
	output logic                           bit_out,
	output logic [b2da_pkg::DIGIT_W-1:0]   digit
);

	logic [b2da_pkg::DIGIT_W-1:0] digit_q;
	logic [b2da_pkg::DIGIT_W-1:0] adj;

	// Add three to digits of five and more, so the following shift carries correctly.
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[b2da_pkg::DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			case (op)
				b2da_pkg::CELL_CLEAR:  digit_q <= '0;
				b2da_pkg::CELL_DABBLE: digit_q <= {adj[b2da_pkg::DIGIT_W-2:0], bit_in};
				b2da_pkg::CELL_SHIFT:  digit_q <= digit_in;
				default:               digit_q <= digit_q;
			endcase
		end
	end

endmodule

// ===== hdl/b2da_ctrl.sv =====
// Sequencer of the converter: holds the binary shift register and steps the chain
// through conversion, leading-zero trimming and digit emission. Depends on b2da_pkg.
module b2da_ctrl #(
	parameter int unsigned MAX_DIGITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [b2da_pkg::VALUE_W-1:0]  in_value,
	input  logic                          top_zero,
	input  logic                          out_free,
	output b2da_pkg::ctrl_t               ctrl
);

	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

	b2da_pkg::state_t state_q, state_d;
	logic [b2da_pkg::VALUE_W-1:0]   bin_q;
	logic [b2da_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic [CNT_W-1:0]               dig_cnt_q;
	logic                           more_digits;

	assign more_digits = (dig_cnt_q > CNT_W'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			b2da_pkg::ST_IDLE: if (in_valid) state_d = b2da_pkg::ST_CONV;
			b2da_pkg::ST_CONV: if (bit_cnt_q == b2da_pkg::LAST_BIT) state_d = b2da_pkg::ST_TRIM;
			b2da_pkg::ST_TRIM: if (!(more_digits && top_zero)) state_d = b2da_pkg::ST_EMIT;
			b2da_pkg::ST_EMIT: if (out_free && !more_digits) state_d = b2da_pkg::ST_IDLE;
			default:           state_d = b2da_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		ctrl.op      = b2da_pkg::CELL_HOLD;
		ctrl.ser_bit = bin_q[b2da_pkg::VALUE_W-1];
		ctrl.emit    = 1'b0;
		ctrl.is_last = !more_digits;
		case (state_q)
			b2da_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) ctrl.op = b2da_pkg::CELL_CLEAR;
			end
			b2da_pkg::ST_CONV: ctrl.op = b2da_pkg::CELL_DABBLE;
			b2da_pkg::ST_TRIM: if (more_digits && top_zero) ctrl.op = b2da_pkg::CELL_SHIFT;
			b2da_pkg::ST_EMIT: begin
				if (out_free) begin
					ctrl.op   = b2da_pkg::CELL_SHIFT;
					ctrl.emit = 1'b1;
				end
			end
			default: ctrl.op = b2da_pkg::CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= b2da_pkg::ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == b2da_pkg::ST_IDLE) begin
				bit_cnt_q <= '0;
			end else if (state_q == b2da_pkg::ST_CONV) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (state_q == b2da_pkg::ST_CONV) begin
				dig_cnt_q <= CNT_W'(MAX_DIGITS);
			end else if (ctrl.op == b2da_pkg::CELL_SHIFT) begin
				dig_cnt_q <= dig_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == b2da_pkg::ST_IDLE) begin
			bin_q <= in_value;
		end else if (state_q == b2da_pkg::ST_CONV) begin
			bin_q <= {bin_q[b2da_pkg::VALUE_W-2:0], 1'b0};
		end
	end

endmodule
